// ----- hw/rtl/i2cbm_pkg.sv -----
package i2cbm_pkg;

  // Bus phase codes
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_ST_SDA_REL = 4'd1;
  localparam logic [3:0] PH_ST_SCL_REL = 4'd2;
  localparam logic [3:0] PH_ST_SDA_LOW = 4'd3;
  localparam logic [3:0] PH_ST_SCL_LOW = 4'd4;
  localparam logic [3:0] PH_WR_SETUP   = 4'd5;
  localparam logic [3:0] PH_WR_HIGH    = 4'd6;
  localparam logic [3:0] PH_WR_LOW     = 4'd7;
  localparam logic [3:0] PH_RD_LOW     = 4'd8;
  localparam logic [3:0] PH_RD_HIGH    = 4'd9;
  localparam logic [3:0] PH_AK_SETUP   = 4'd10;
  localparam logic [3:0] PH_AK_HIGH    = 4'd11;
  localparam logic [3:0] PH_AK_LOW     = 4'd12;
  localparam logic [3:0] PH_SP_SDA_LOW = 4'd13;
  localparam logic [3:0] PH_SP_SCL_REL = 4'd14;
  localparam logic [3:0] PH_SP_SDA_REL = 4'd15;

  // Command codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_RDACK = 3'd3;
  localparam logic [2:0] OP_RDNAK = 3'd4;
  localparam logic [2:0] OP_ACK   = 3'd5;
  localparam logic [2:0] OP_NACK  = 3'd6;
  localparam logic [2:0] OP_PROBE = 3'd7;

  // Register indexes
  localparam logic [7:0] REG_SETUP = 8'd0;
  localparam logic [7:0] REG_HIGH  = 8'd1;
  localparam logic [7:0] REG_LOW   = 8'd2;
  localparam logic [7:0] REG_HOLD  = 8'd3;

  localparam logic [7:0] SETUP_RESET = 8'd10;
  localparam logic [7:0] HIGH_RESET  = 8'd50;
  localparam logic [7:0] LOW_RESET   = 8'd10;
  localparam logic [7:0] HOLD_RESET  = 8'd100;

  localparam logic [7:0] MSB_MASK  = 8'h80;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Phase lengths in ticks, zero already mapped to one
  typedef struct packed {
    logic [7:0] setup_len;
    logic [7:0] high_len;
    logic [7:0] low_len;
    logic [7:0] hold_len;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       bus_error;
  } res_t;

endpackage

// ----- hw/rtl/i2c_byte_master.sv -----
// Channel   Direction  Handshake               Payload
// in        in         in_valid / in_stall     cmd_valid operation tx_byte sda_in scl_in
// out       out        out_valid / out_stall   scl_pull_low sda_pull_low busy_res done_res
//                                              rx_byte ack_bit bus_error
// cfg       in         cfg_valid / cfg_ready   cfg_index cfg_data
//
// One item is one bus tick; its result is loaded at the edge that accepts it, into the
// output register if free or emptied, else into its skid entry. The block sustains one
// item per cycle while in_stall is low. The phase state machine updates at that edge.
// Reset (rst, synchronous) releases both lines, idles the controller and loads the
// default timing registers. in_stall rises only when the output register and its skid
// entry both hold results; cfg_ready is always high.
module i2c_byte_master import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd_valid,
  input  logic [2:0] operation,
  input  logic [7:0] tx_byte,
  input  logic       sda_in,
  input  logic       scl_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_pull_low,
  output logic       sda_pull_low,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       ack_bit,
  output logic       bus_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  res_t res_next;
  res_t head;
  logic push;
  logic full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign push      = in_valid && !full;

  i2cbm_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  i2cbm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .cmd_valid (cmd_valid),
    .operation (operation),
    .tx_byte   (tx_byte),
    .sda_in    (sda_in),
    .scl_in    (scl_in),
    .res_next  (res_next)
  );

  i2cbm_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .res_in     (res_next),
    .full       (full),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head       (head)
  );

  // Spread the result item onto its ports
  assign scl_pull_low = head.scl_pull_low;
  assign sda_pull_low = head.sda_pull_low;
  assign busy_res     = head.busy_res;
  assign done_res     = head.done_res;
  assign rx_byte      = head.rx_byte;
  assign ack_bit      = head.ack_bit;
  assign bus_error    = head.bus_error;

endmodule

// ----- hw/rtl/i2cbm_regs.sv -----
module i2cbm_regs import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  logic [7:0] index,
  input  logic [7:0] data,
  output cfg_t       cfg
);

  logic [7:0] setup_ticks;
  logic [7:0] high_ticks;
  logic [7:0] low_ticks;
  logic [7:0] hold_ticks;

  // Write one timing register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      setup_ticks <= SETUP_RESET;
      high_ticks  <= HIGH_RESET;
      low_ticks   <= LOW_RESET;
      hold_ticks  <= HOLD_RESET;
    end else if (wr) begin
      unique case (index)
        REG_SETUP: setup_ticks <= data;
        REG_HIGH:  high_ticks  <= data;
        REG_LOW:   low_ticks   <= data;
        REG_HOLD:  hold_ticks  <= data;
        default: ;
      endcase
    end
  end

  // Treat a zero length as one tick
  assign cfg.setup_len = (setup_ticks == 8'd0) ? 8'd1 : setup_ticks;
  assign cfg.high_len  = (high_ticks  == 8'd0) ? 8'd1 : high_ticks;
  assign cfg.low_len   = (low_ticks   == 8'd0) ? 8'd1 : low_ticks;
  assign cfg.hold_len  = (hold_ticks  == 8'd0) ? 8'd1 : hold_ticks;

endmodule

// ----- hw/rtl/i2cbm_core.sv -----
module i2cbm_core import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       push,
  input  logic       cmd_valid,
  input  logic [2:0] operation,
  input  logic [7:0] tx_byte,
  input  logic       sda_in,
  input  logic       scl_in,
  output res_t       res_next
);

  logic [3:0] phase, phase_next;
  logic [2:0] current_op, current_op_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] tick_count, tick_count_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       ack_hold, ack_hold_next;
  logic       error_hold, error_hold_next;

  logic       done;
  logic       go;
  logic       finish;
  logic [3:0] go_ph;
  logic [7:0] len;
  logic [1:0] drv;

  // Length of a phase in ticks
  function automatic logic [7:0] phase_len(input logic [3:0] ph, input cfg_t c);
    logic [7:0] r;
    unique case (ph)
      PH_ST_SDA_REL, PH_ST_SCL_REL, PH_WR_SETUP,
      PH_AK_SETUP, PH_SP_SDA_LOW:           r = c.setup_len;
      PH_WR_HIGH, PH_RD_HIGH, PH_AK_HIGH:   r = c.high_len;
      PH_WR_LOW, PH_RD_LOW, PH_AK_LOW:      r = c.low_len;
      default:                              r = c.hold_len;
    endcase
    return r;
  endfunction

  // Line drives on entering a phase, returned as {scl, sda}
  function automatic logic [1:0] enter_drv(input logic [3:0] ph, input logic [3:0] bc,
                                           input logic [7:0] sr, input logic [2:0] op,
                                           input logic scl, input logic sda);
    logic s_c;
    logic s_d;
    s_c = scl;
    s_d = sda;
    unique case (ph)
      PH_ST_SDA_REL: s_d = 1'b0;
      PH_ST_SCL_REL: s_c = 1'b0;
      PH_ST_SDA_LOW: s_d = 1'b1;
      PH_ST_SCL_LOW: s_c = 1'b1;
      PH_WR_SETUP: begin
        s_c = 1'b1;
        s_d = (bc < BYTE_BITS) && ((sr & MSB_MASK) == 8'd0);
      end
      PH_WR_HIGH: s_c = 1'b0;
      PH_WR_LOW:  s_c = 1'b1;
      PH_RD_LOW: begin
        s_c = 1'b1;
        s_d = 1'b0;
      end
      PH_RD_HIGH: s_c = 1'b0;
      PH_AK_SETUP: begin
        s_c = 1'b1;
        s_d = (op == OP_RDACK) || (op == OP_ACK);
      end
      PH_AK_HIGH: s_c = 1'b0;
      PH_AK_LOW: begin
        s_c = 1'b1;
        s_d = 1'b0;
      end
      PH_SP_SDA_LOW: begin
        s_c = 1'b1;
        s_d = 1'b1;
      end
      PH_SP_SCL_REL: s_c = 1'b0;
      PH_SP_SDA_REL: s_d = 1'b0;
      default: ;
    endcase
    return {s_c, s_d};
  endfunction

  assign len = phase_len(phase, cfg);

  // Work out one tick: accept a command when idle, else count and advance phases
  always_comb begin
    current_op_next = current_op;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    tick_count_next = tick_count;
    rx_hold_next    = rx_hold;
    ack_hold_next   = ack_hold;
    error_hold_next = error_hold;
    done            = 1'b0;
    go              = 1'b0;
    finish          = 1'b0;
    go_ph           = phase;

    if (phase == PH_IDLE) begin
      if (cmd_valid) begin
        current_op_next = operation;
        bit_count_next  = 4'd0;
        unique case (operation)
          OP_START: begin
            go = 1'b1;
            go_ph = PH_ST_SDA_REL;
          end
          OP_STOP: begin
            go = 1'b1;
            go_ph = PH_SP_SDA_LOW;
          end
          OP_WRITE: begin
            shift_reg_next = tx_byte;
            go = 1'b1;
            go_ph = PH_WR_SETUP;
          end
          OP_RDACK, OP_RDNAK: begin
            shift_reg_next = 8'd0;
            go = 1'b1;
            go_ph = PH_RD_LOW;
          end
          OP_ACK, OP_NACK: begin
            go = 1'b1;
            go_ph = PH_AK_SETUP;
          end
          default: begin
            // Probe: fail at once if the bus is not idle
            if (!sda_in || !scl_in) begin
              error_hold_next = 1'b1;
              ack_hold_next   = 1'b1;
              done            = 1'b1;
            end else begin
              error_hold_next = 1'b0;
              shift_reg_next  = tx_byte;
              go = 1'b1;
              go_ph = PH_ST_SDA_REL;
            end
          end
        endcase
      end
    end else if (({1'b0, tick_count} + 9'd1) >= {1'b0, len}) begin
      go = 1'b1;
      unique case (phase)
        PH_ST_SDA_REL: go_ph = PH_ST_SCL_REL;
        PH_ST_SCL_REL: go_ph = PH_ST_SDA_LOW;
        PH_ST_SDA_LOW: go_ph = PH_ST_SCL_LOW;
        PH_ST_SCL_LOW: begin
          if (current_op == OP_PROBE) begin
            bit_count_next = 4'd0;
            go_ph = PH_WR_SETUP;
          end else begin
            go = 1'b0;
            finish = 1'b1;
          end
        end
        PH_WR_SETUP: go_ph = PH_WR_HIGH;
        PH_WR_HIGH: begin
          if (bit_count >= BYTE_BITS) ack_hold_next = sda_in;
          go_ph = PH_WR_LOW;
        end
        PH_WR_LOW: begin
          if (bit_count < BYTE_BITS) begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_count_next = bit_count + 4'd1;
            go_ph = PH_WR_SETUP;
          end else if (current_op == OP_PROBE) begin
            go_ph = PH_SP_SDA_LOW;
          end else begin
            go = 1'b0;
            finish = 1'b1;
          end
        end
        PH_RD_LOW: go_ph = PH_RD_HIGH;
        PH_RD_HIGH: begin
          shift_reg_next = {shift_reg[6:0], sda_in};
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next < BYTE_BITS) begin
            go_ph = PH_RD_LOW;
          end else begin
            rx_hold_next = shift_reg_next;
            go_ph = PH_AK_SETUP;
          end
        end
        PH_AK_SETUP:   go_ph = PH_AK_HIGH;
        PH_AK_HIGH:    go_ph = PH_AK_LOW;
        PH_SP_SDA_LOW: go_ph = PH_SP_SCL_REL;
        PH_SP_SCL_REL: go_ph = PH_SP_SDA_REL;
        PH_AK_LOW, PH_SP_SDA_REL, PH_IDLE: begin
          go = 1'b0;
          finish = 1'b1;
        end
      endcase
    end else begin
      tick_count_next = tick_count + 8'd1;
    end

    drv = enter_drv(go_ph, bit_count_next, shift_reg_next, current_op_next,
                    scl_drive, sda_drive);
    phase_next     = phase;
    scl_drive_next = scl_drive;
    sda_drive_next = sda_drive;
    if (go) begin
      phase_next      = go_ph;
      tick_count_next = 8'd0;
      scl_drive_next  = drv[1];
      sda_drive_next  = drv[0];
    end
    if (finish) begin
      phase_next      = PH_IDLE;
      tick_count_next = 8'd0;
      done            = 1'b1;
    end
  end

  // Result of this tick, taken from the updated state
  always_comb begin
    res_next.scl_pull_low = scl_drive_next;
    res_next.sda_pull_low = sda_drive_next;
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.done_res     = done;
    res_next.rx_byte      = rx_hold_next;
    res_next.ack_bit      = ack_hold_next;
    res_next.bus_error    = error_hold_next;
  end

  // Hold state between items, advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      current_op <= OP_START;
      bit_count  <= 4'd0;
      shift_reg  <= 8'd0;
      tick_count <= 8'd0;
      scl_drive  <= 1'b0;
      sda_drive  <= 1'b0;
      rx_hold    <= 8'd0;
      ack_hold   <= 1'b0;
      error_hold <= 1'b0;
    end else if (push) begin
      phase      <= phase_next;
      current_op <= current_op_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      tick_count <= tick_count_next;
      scl_drive  <= scl_drive_next;
      sda_drive  <= sda_drive_next;
      rx_hold    <= rx_hold_next;
      ack_hold   <= ack_hold_next;
      error_hold <= error_hold_next;
    end
  end

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == 8'd0))
    else $error("tick count running while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BYTE_BITS)
    else $error("bit count beyond one byte");

  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (tick_count < len))
    else $error("tick count past phase length");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (push && done) |=> (phase == PH_IDLE))
    else $error("completion left controller busy");

endmodule

// ----- hw/rtl/i2cbm_out.sv -----
module i2cbm_out import i2cbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t res_in,
  output logic full,
  output logic head_valid,
  input  logic head_stall,
  output res_t head
);

  logic skid_valid;
  res_t skid;
  logic pop;

  assign pop  = head_valid && !head_stall;
  assign full = skid_valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Move payload alongside the valid bits
  always_ff @(posedge clk) begin
    if (pop) begin
      head <= skid_valid ? skid : res_in;
    end else if (push && !head_valid) begin
      head <= res_in;
    end
    if (!pop && push && head_valid) begin
      skid <= res_in;
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry without head entry");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("item pushed into full buffer");

endmodule
